FILE: hw/rtl/crank_port_opening_calc_macros.svh
// Assertion macros for the crank port opening calculator
`ifndef CRANK_PORT_OPENING_CALC_MACROS_SVH
`define CRANK_PORT_OPENING_CALC_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPOC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpoc assertion failed");
`define CPOC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpoc assertion failed");
`else
`define CPOC_ASSERT_IMP(name, ante, cons)
`define CPOC_ASSERT_NXT(name, ante, cons)
`endif
`endif

FILE: hw/rtl/cpoc_pkg.sv
// Shared types, constants and tables for the crank port opening calculator
package cpoc_pkg;

  localparam int IDX_W   = 13;
  localparam int STEPS_W = 13;
  localparam int LEN_W   = 16;
  localparam int ROD_W   = 17;
  localparam int CFG_W   = 17;
  localparam int REGI_W  = 3;
  localparam int ANG_W   = 32;
  localparam int TRIG_W  = 32;
  localparam int HS_W    = 27;
  localparam int ROOT_W  = 26;
  localparam int P_W     = 20;

  localparam int MAX_STEPS_DEF   = 4096;
  localparam int TRIG_ITER_DEF   = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_START    = 652032874;
  localparam int ONE_Q30         = 1073741824;

  localparam logic [LEN_W-1:0]   STROKE_RST = 16'd13824;
  localparam logic [ROD_W-1:0]   ROD_RST    = 17'd28160;
  localparam logic [LEN_W-1:0]   EXH_H_RST  = 16'd7680;
  localparam logic [LEN_W-1:0]   EXH_O_RST  = 16'd6400;
  localparam logic [LEN_W-1:0]   XFER_H_RST = 16'd3840;
  localparam logic [LEN_W-1:0]   XFER_O_RST = 16'd0;
  localparam logic [STEPS_W-1:0] STEPS_RST  = 13'd360;

  typedef enum logic [REGI_W-1:0] {
    REG_STROKE = 3'd0,
    REG_ROD    = 3'd1,
    REG_EXH_H  = 3'd2,
    REG_EXH_O  = 3'd3,
    REG_XFER_H = 3'd4,
    REG_XFER_O = 3'd5,
    REG_STEPS  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0] stroke;
    logic [ROD_W-1:0] rod;
  } cpoc_geom_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/cpoc_angle_div.sv
// Pipelined restoring divider: angle fraction = index * 2^32 / steps
module cpoc_angle_div import cpoc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [IDX_W-1:0]   in_idx,
  input  logic [STEPS_W-1:0] steps,
  output logic               out_vld,
  output logic [ANG_W-1:0]   out_ang
);

  localparam int NUM_W = IDX_W + ANG_W;
  localparam int PER   = 3;
  localparam int NSTG  = NUM_W / PER;
  localparam int REM_W = STEPS_W + 1;

  logic             vld_r [NSTG];
  logic [NUM_W-1:0] num_r [NSTG];
  logic [REM_W-1:0] rem_r [NSTG];
  logic [ANG_W-1:0] quo_r [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic             vld_i;
    logic [NUM_W-1:0] num_i, num_nxt;
    logic [REM_W-1:0] rem_i, rem_nxt;
    logic [ANG_W-1:0] quo_i, quo_nxt;

    if (g == 0) begin : g_first
      assign vld_i = in_vld;
      assign num_i = {in_idx, {ANG_W{1'b0}}};
      assign rem_i = '0;
      assign quo_i = '0;
    end else begin : g_rest
      assign vld_i = vld_r[g-1];
      assign num_i = num_r[g-1];
      assign rem_i = rem_r[g-1];
      assign quo_i = quo_r[g-1];
    end

    always_comb begin
      num_nxt = num_i;
      rem_nxt = rem_i;
      quo_nxt = quo_i;
      for (int k = 0; k < PER; k++) begin
        rem_nxt = {rem_nxt[REM_W-2:0], num_nxt[NUM_W-1]};
        num_nxt = {num_nxt[NUM_W-2:0], 1'b0};
        if (rem_nxt >= {1'b0, steps}) begin
          rem_nxt = rem_nxt - {1'b0, steps};
          quo_nxt = {quo_nxt[ANG_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[ANG_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv) begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[g] <= num_nxt;
        rem_r[g] <= rem_nxt;
        quo_r[g] <= quo_nxt;
      end
    end
  end

  // a zero step count means angle zero
  assign out_vld = vld_r[NSTG-1];
  assign out_ang = (steps == '0) ? '0 : quo_r[NSTG-1];

endmodule

FILE: hw/rtl/cpoc_cordic.sv
// Pipelined rotation CORDIC giving sine and cosine with quadrant fold
module cpoc_cordic import cpoc_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic [ANG_W-1:0]         in_ang,
  output logic                     out_vld,
  output logic signed [TRIG_W-1:0] out_sin,
  output logic signed [TRIG_W-1:0] out_cos
);

  localparam int W = 33;
  localparam logic signed [W-1:0] START = W'(CORDIC_START);
  localparam logic signed [W-1:0] ONE   = W'(ONE_Q30);

  logic              vld_r [TRIG_ITERATIONS];
  logic signed [W-1:0] x_r [TRIG_ITERATIONS];
  logic signed [W-1:0] y_r [TRIG_ITERATIONS];
  logic signed [W-1:0] z_r [TRIG_ITERATIONS];
  logic [1:0]          q_r [TRIG_ITERATIONS];

  for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_it
    localparam logic signed [W-1:0] ATN = $signed(W'(atan_turn(g)));
    logic              vld_i;
    logic signed [W-1:0] x_i, y_i, z_i, x_nxt, y_nxt, z_nxt;
    logic [1:0]          q_i;

    if (g == 0) begin : g_first
      assign vld_i = in_vld;
      assign x_i   = START;
      assign y_i   = '0;
      assign z_i   = $signed({{(W-30){1'b0}}, in_ang[29:0]});
      assign q_i   = in_ang[ANG_W-1:ANG_W-2];
    end else begin : g_rest
      assign vld_i = vld_r[g-1];
      assign x_i   = x_r[g-1];
      assign y_i   = y_r[g-1];
      assign z_i   = z_r[g-1];
      assign q_i   = q_r[g-1];
    end

    always_comb begin
      if (!z_i[W-1]) begin
        x_nxt = x_i - (y_i >>> g);
        y_nxt = y_i + (x_i >>> g);
        z_nxt = z_i - ATN;
      end else begin
        x_nxt = x_i + (y_i >>> g);
        y_nxt = y_i - (x_i >>> g);
        z_nxt = z_i + ATN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv) begin
        vld_r[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[g] <= x_nxt;
        y_r[g] <= y_nxt;
        z_r[g] <= z_nxt;
        q_r[g] <= q_i;
      end
    end
  end

  logic signed [W-1:0] xc, yc, s_full, c_full;
  logic                out_vld_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  always_comb begin
    xc = x_r[TRIG_ITERATIONS-1];
    yc = y_r[TRIG_ITERATIONS-1];
    if (xc > ONE) xc = ONE;
    if (xc < -ONE) xc = -ONE;
    if (yc > ONE) yc = ONE;
    if (yc < -ONE) yc = -ONE;
    unique case (q_r[TRIG_ITERATIONS-1])
      2'd0: begin c_full = xc;  s_full = yc;  end
      2'd1: begin c_full = -yc; s_full = xc;  end
      2'd2: begin c_full = -xc; s_full = -yc; end
      default: begin c_full = yc; s_full = -xc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[TRIG_ITERATIONS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_r <= $signed(s_full[TRIG_W-1:0]);
      cos_r <= $signed(c_full[TRIG_W-1:0]);
    end
  end

  assign out_vld = out_vld_r;
  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule

FILE: hw/rtl/cpoc_drop.sv
// Piston drop: products, squares, pipelined square root and rounding
module cpoc_drop import cpoc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  cpoc_geom_t               geom,
  input  logic                     in_vld,
  input  logic signed [TRIG_W-1:0] in_sin,
  input  logic signed [TRIG_W-1:0] in_cos,
  output logic                     out_vld,
  output logic [P_W-1:0]           out_p
);

  localparam int PROD_W = LEN_W + 1 + TRIG_W;
  localparam int SQ_W   = 2 * HS_W;
  localparam int SQK_W  = 49;
  localparam int RR_W   = 2 * ROD_W;
  localparam int ARG_W  = 2 * ROOT_W;
  localparam int DIF_W  = ARG_W + 2;
  localparam int PER    = 2;
  localparam int NSTG   = ROOT_W / PER;
  localparam int RS_W   = ROOT_W + 4;
  localparam int D_W    = 29;

  // stage 1: h*sin and h*cos, floored to 2^-17 mm
  logic signed [PROD_W-1:0] ps, pc;
  logic signed [HS_W-1:0]   hs_r, hc1_r;
  logic                     v1_r;

  assign ps = $signed({1'b0, geom.stroke}) * in_sin;
  assign pc = $signed({1'b0, geom.stroke}) * in_cos;

  // stage 2: squares
  logic signed [SQ_W-1:0] sq_full;
  logic [RR_W-1:0]        rr_full;
  logic [SQK_W-1:0]       sq_r;
  logic [RR_W-1:0]        rr_r;
  logic signed [HS_W-1:0] hc2_r;
  logic                   v2_r;

  assign sq_full = hs_r * hs_r;
  assign rr_full = geom.rod * geom.rod;

  // stage 3: root argument, negative saturates to zero
  logic signed [DIF_W-1:0] dif;
  logic [ARG_W-1:0]        arg_r;
  logic signed [HS_W-1:0]  hc3_r;
  logic                    v3_r;

  assign dif = $signed({2'b0, rr_r, 18'b0}) - $signed({5'b0, sq_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hs_r  <= HS_W'(ps >>> 22);
      hc1_r <= HS_W'(pc >>> 22);
      sq_r  <= SQK_W'(sq_full);
      rr_r  <= rr_full;
      hc2_r <= hc1_r;
      arg_r <= dif[DIF_W-1] ? '0 : dif[ARG_W-1:0];
      hc3_r <= hc2_r;
    end
  end

  // square root, two result bits per stage
  logic                   sv_r  [NSTG];
  logic [ARG_W-1:0]       sa_r  [NSTG];
  logic [RS_W-1:0]        srem_r[NSTG];
  logic [ROOT_W-1:0]      sroot_r[NSTG];
  logic signed [HS_W-1:0] shc_r [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_sq
    logic                   v_i;
    logic [ARG_W-1:0]       a_i, a_nxt;
    logic [RS_W-1:0]        r_i, r_nxt, trial;
    logic [ROOT_W-1:0]      q_i, q_nxt;
    logic signed [HS_W-1:0] hc_i;

    if (g == 0) begin : g_first
      assign v_i  = v3_r;
      assign a_i  = arg_r;
      assign r_i  = '0;
      assign q_i  = '0;
      assign hc_i = hc3_r;
    end else begin : g_rest
      assign v_i  = sv_r[g-1];
      assign a_i  = sa_r[g-1];
      assign r_i  = srem_r[g-1];
      assign q_i  = sroot_r[g-1];
      assign hc_i = shc_r[g-1];
    end

    always_comb begin
      a_nxt = a_i;
      r_nxt = r_i;
      q_nxt = q_i;
      trial = '0;
      for (int k = 0; k < PER; k++) begin
        r_nxt = {r_nxt[RS_W-3:0], a_nxt[ARG_W-1:ARG_W-2]};
        a_nxt = {a_nxt[ARG_W-3:0], 2'b00};
        trial = {2'b00, q_nxt, 2'b01};
        if (r_nxt >= trial) begin
          r_nxt = r_nxt - trial;
          q_nxt = {q_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[g] <= 1'b0;
      end else if (adv) begin
        sv_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sa_r[g]    <= a_nxt;
        srem_r[g]  <= r_nxt;
        sroot_r[g] <= q_nxt;
        shc_r[g]   <= hc_i;
      end
    end
  end

  // drop and rounding to 1/256 mm
  logic signed [D_W-1:0] d, d_rnd;
  logic [P_W-1:0]        p_r;
  logic                  pv_r;

  assign d = $signed({3'b0, geom.rod, 9'b0}) + $signed({5'b0, geom.stroke, 8'b0})
           - D_W'(shc_r[NSTG-1]) - $signed({3'b0, sroot_r[NSTG-1]});
  assign d_rnd = d + D_W'(256);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= sv_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= d[D_W-1] ? '0 : P_W'(d_rnd >>> 9);
    end
  end

  assign out_vld = pv_r;
  assign out_p   = p_r;

endmodule

FILE: hw/rtl/crank_port_opening_calc.sv
// Top level: configuration registers, pipeline chain and result register
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Divider (15 stages), CORDIC (TRIG_ITERATIONS + 1), drop path with root (17), output (1).
// Reset: synchronous active-low rst_n clears all valid bits and loads register defaults.
`include "crank_port_opening_calc_macros.svh"
module crank_port_opening_calc import cpoc_pkg::*; #(
  parameter int MAX_STEPS       = MAX_STEPS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [REGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IDX_W-1:0]  in_angle_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEN_W-1:0]  out_piston_drop,
  output logic [LEN_W-1:0]  out_intake_opening,
  output logic [LEN_W-1:0]  out_exhaust_opening
);

  localparam int T_W = P_W + 2;

  logic [LEN_W-1:0]   stroke_r, exh_h_r, exh_o_r, xfer_h_r, xfer_o_r;
  logic [ROD_W-1:0]   rod_r;
  logic [STEPS_W-1:0] steps_r, steps_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stroke_r <= STROKE_RST;
      rod_r    <= ROD_RST;
      exh_h_r  <= EXH_H_RST;
      exh_o_r  <= EXH_O_RST;
      xfer_h_r <= XFER_H_RST;
      xfer_o_r <= XFER_O_RST;
      steps_r  <= STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STROKE: stroke_r <= cfg_data[LEN_W-1:0];
        REG_ROD:    rod_r    <= cfg_data[ROD_W-1:0];
        REG_EXH_H:  exh_h_r  <= cfg_data[LEN_W-1:0];
        REG_EXH_O:  exh_o_r  <= cfg_data[LEN_W-1:0];
        REG_XFER_H: xfer_h_r <= cfg_data[LEN_W-1:0];
        REG_XFER_O: xfer_o_r <= cfg_data[LEN_W-1:0];
        REG_STEPS:  steps_r  <= cfg_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign steps_eff = (32'(steps_r) > MAX_STEPS) ? STEPS_W'(MAX_STEPS) : steps_r;

  // the pipeline moves whenever the result register is free or being taken
  logic adv, out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  logic                     dv_vld, cr_vld, dr_vld;
  logic [ANG_W-1:0]         dv_ang;
  logic signed [TRIG_W-1:0] cr_sin, cr_cos;
  logic [P_W-1:0]           dr_p;
  cpoc_geom_t               geom;

  assign geom.stroke = stroke_r;
  assign geom.rod    = rod_r;

  cpoc_angle_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_idx  (in_angle_index),
    .steps   (steps_eff),
    .out_vld (dv_vld),
    .out_ang (dv_ang)
  );

  cpoc_cordic #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (dv_vld),
    .in_ang  (dv_ang),
    .out_vld (cr_vld),
    .out_sin (cr_sin),
    .out_cos (cr_cos)
  );

  cpoc_drop u_drop (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .geom    (geom),
    .in_vld  (cr_vld),
    .in_sin  (cr_sin),
    .in_cos  (cr_cos),
    .out_vld (dr_vld),
    .out_p   (dr_p)
  );

  // port openings from the unsaturated drop
  logic signed [T_W-1:0] t_in, t_ex;
  logic [LEN_W-1:0]      in_open, ex_open, drop_sat;
  logic [LEN_W-1:0]      drop_r, in_open_r, ex_open_r;

  assign t_in = $signed({2'b0, dr_p}) - $signed(T_W'(stroke_r))
              + $signed(T_W'(xfer_h_r)) + $signed(T_W'(xfer_o_r));
  assign t_ex = $signed({2'b0, dr_p}) - $signed(T_W'(exh_o_r));

  always_comb begin
    if (t_in[T_W-1]) begin
      in_open = '0;
    end else if (t_in > $signed(T_W'(xfer_h_r))) begin
      in_open = xfer_h_r;
    end else begin
      in_open = t_in[LEN_W-1:0];
    end
    if (t_ex[T_W-1]) begin
      ex_open = '0;
    end else if (t_ex > $signed(T_W'(exh_h_r))) begin
      ex_open = exh_h_r;
    end else begin
      ex_open = t_ex[LEN_W-1:0];
    end
    drop_sat = (dr_p > P_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : dr_p[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drop_r    <= drop_sat;
      in_open_r <= in_open;
      ex_open_r <= ex_open;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_piston_drop     = drop_r;
  assign out_intake_opening  = in_open_r;
  assign out_exhaust_opening = ex_open_r;

  `CPOC_ASSERT_IMP(a_intake_bound, out_valid_r, in_open_r <= xfer_h_r)
  `CPOC_ASSERT_IMP(a_exhaust_bound, out_valid_r, ex_open_r <= exh_h_r)
  `CPOC_ASSERT_NXT(a_hold_on_stall, out_valid_r && out_stall, out_valid_r)

endmodule
